[hw/rtl/hec_pkg.sv]
package hec_pkg;

    localparam int NUM_BINS_DEF    = 100;
    localparam int HALF_WINDOW_DEF = 10;
    localparam int NUM_REGIONS_DEF = 4;

    localparam int ROW_W   = 6;
    localparam int SEC_W   = 5;
    localparam int TB_W    = 10;
    localparam int WL_W    = 10;
    localparam int REG_W   = 2;
    localparam int EDGE_W  = 18;
    localparam int FRAC_W  = 8;
    localparam int COUNT_W = 15;
    localparam int DIFF_W  = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [WL_W-1:0]  WINDOW_LOW_RST = 10'd310;
    localparam logic [ROW_W-1:0] INNER_ROW_RST  = 6'd13;
    localparam logic [SEC_W-1:0] SIDE_SEC_RST   = 5'd12;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LOW  = 2'd0,
        CFG_INNER_ROW   = 2'd1,
        CFG_SIDE_SECTOR = 2'd2
    } t_cfg_idx;

    // divider widths cover the full parameter range
    localparam int DIV_NUM_W = 44;
    localparam int DIV_DEN_W = 23;

    typedef struct packed {
        logic                        start;
        logic signed [DIV_NUM_W-1:0] num;
        logic signed [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [EDGE_W-1:0] quot;
    } t_div_rsp;

endpackage

[hw/rtl/hec_hit_if.sv]
interface hec_hit_if;
    logic                        valid;
    logic                        ready;
    logic [hec_pkg::ROW_W-1:0]   pad_row;
    logic [hec_pkg::SEC_W-1:0]   sector_number;
    logic [hec_pkg::TB_W-1:0]    time_bucket;
    logic                        last_hit;

    modport source (output valid, pad_row, sector_number, time_bucket, last_hit,
                    input ready);
    modport sink   (input valid, pad_row, sector_number, time_bucket, last_hit,
                    output ready);
endinterface

[hw/rtl/hec_res_if.sv]
interface hec_res_if;
    logic                              valid;
    logic                              ready;
    logic [hec_pkg::REG_W-1:0]         region;
    logic signed [hec_pkg::EDGE_W-1:0] edge_time;
    logic                              zero_weight;
    logic                              last_region;

    modport source (output valid, region, edge_time, zero_weight, last_region,
                    input ready);
    modport sink   (input valid, region, edge_time, zero_weight, last_region,
                    output ready);
endinterface

[hw/rtl/hec_cfg_if.sv]
interface hec_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [hec_pkg::CFG_IDX_W-1:0]      index;
    logic [hec_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/hec_ram.sv]
module hec_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 400
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word when read and write hit the same address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/hec_div.sv]
module hec_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hec_pkg::t_div_req i_req,
    output hec_pkg::t_div_rsp o_rsp
);
    localparam int QB   = hec_pkg::EDGE_W;
    localparam int DV_A = hec_pkg::DIV_NUM_W + 2;
    localparam int DV_B = hec_pkg::DIV_DEN_W + 1 + QB;
    localparam int DV_W = (DV_A > DV_B) ? DV_A : DV_B;
    localparam int CNT_W = $clog2(QB);

    localparam logic [QB-1:0] POS_LIM = {1'b0, {(QB-1){1'b1}}};
    localparam logic [QB-1:0] NEG_LIM = {1'b1, {(QB-1){1'b0}}};

    logic [hec_pkg::DIV_NUM_W-1:0] an;
    logic [hec_pkg::DIV_DEN_W-1:0] ad;
    logic [DV_W-1:0]  r_rem, r_div, r_dsh;
    logic [QB-1:0]    r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg, r_ovf, r_pre, r_busy, r_fin, r_done;
    logic [QB-1:0]    r_quot;
    logic [QB-1:0]    n_quot;
    logic             ge;

    assign an = i_req.num[hec_pkg::DIV_NUM_W-1] ? hec_pkg::DIV_NUM_W'(-i_req.num)
                                                 : i_req.num;
    assign ad = i_req.den[hec_pkg::DIV_DEN_W-1] ? hec_pkg::DIV_DEN_W'(-i_req.den)
                                                 : i_req.den;
    assign ge = (r_rem >= r_dsh);

    always_comb begin
        if (r_neg) begin
            n_quot = (r_ovf || r_q > NEG_LIM) ? NEG_LIM : QB'(-r_q);
        end else begin
            n_quot = (r_ovf || r_q > POS_LIM) ? POS_LIM : r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre  <= 1'b0;
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_req.start) begin
                // rounded quotient (2|n| + |d|) / (2|d|)
                r_rem <= (DV_W'(an) << 1) + DV_W'(ad);
                r_div <= DV_W'(ad) << 1;
                r_neg <= i_req.num[hec_pkg::DIV_NUM_W-1] ^ i_req.den[hec_pkg::DIV_DEN_W-1];
                r_pre <= 1'b1;
            end else if (r_pre) begin
                r_ovf  <= r_rem >= (r_div << QB);
                r_dsh  <= r_div << (QB - 1);
                r_cnt  <= CNT_W'(QB - 1);
                r_q    <= '0;
                r_pre  <= 1'b0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_q   <= {r_q[QB-2:0], ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_quot <= n_quot;
                r_done <= 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
endmodule

[hw/rtl/histogram_edge_centroid_top.sv]
// Hits: one item per cycle while in the run state, counted by a read-modify-write of the count RAM with forwarding.
// Last hit: per region a difference sweep, a window sum and a division (skipped for a zero weight),
// then one result item; the NUM_REGIONS regions run in turn.
// Input stays blocked from the last hit until the result item of the last region is taken.
// Reset (synchronous, active low) restores the control and configuration registers and runs a clearing pass
// over all NUM_REGIONS*NUM_BINS words of the count RAM; configuration writes are taken throughout.
module histogram_edge_centroid_top #(
    parameter int NUM_BINS    = hec_pkg::NUM_BINS_DEF,
    parameter int HALF_WINDOW = hec_pkg::HALF_WINDOW_DEF,
    parameter int NUM_REGIONS = hec_pkg::NUM_REGIONS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hec_hit_if.sink   i_hit,
    hec_cfg_if.sink   i_cfg,
    hec_res_if.source o_res
);
    localparam int DEPTH  = NUM_REGIONS * NUM_BINS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int BIN_W  = $clog2(NUM_BINS);
    localparam int SK_W   = $clog2(NUM_BINS + 1);
    localparam int KW     = $clog2(NUM_BINS + HALF_WINDOW) + 2;
    localparam int WN_W   = $clog2(2 * HALF_WINDOW + 1);
    localparam int CW     = ((hec_pkg::WL_W > BIN_W) ? hec_pkg::WL_W : BIN_W) + 1;
    localparam int CEN_W  = CW + hec_pkg::FRAC_W;
    localparam int PROD_W = hec_pkg::DIFF_W + CEN_W + 1;
    localparam int ACC_W  = PROD_W + $clog2(2 * HALF_WINDOW) + 1;
    localparam int DEN_W  = hec_pkg::DIFF_W + $clog2(2 * HALF_WINDOW) + 1;
    localparam int COUNT_W = hec_pkg::COUNT_W;
    localparam int DIFF_W  = hec_pkg::DIFF_W;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_RUN   = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_SWEEP = 7'b0001000,
        S_WIN   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;

    logic [hec_pkg::WL_W-1:0]  r_wl;
    logic [hec_pkg::ROW_W-1:0] r_row_lim;
    logic [hec_pkg::SEC_W-1:0] r_sec_lim;

    // ---------------- hit intake ----------------
    logic                  hit_acc;
    logic [hec_pkg::TB_W:0] tb_off;
    logic                  in_win;
    logic [hec_pkg::REG_W-1:0] hit_reg;
    logic [ADDR_W-1:0]     hit_addr;

    assign i_hit.ready = (r_state == S_RUN);
    assign hit_acc     = i_hit.valid && i_hit.ready;
    assign tb_off  = {1'b0, i_hit.time_bucket} - {1'b0, r_wl};
    assign in_win  = (i_hit.time_bucket >= r_wl) &&
                     (tb_off < (hec_pkg::TB_W+1)'(NUM_BINS));
    assign hit_reg = {i_hit.sector_number > r_sec_lim, i_hit.pad_row > r_row_lim};
    assign hit_addr = ADDR_W'(32'(hit_reg) * NUM_BINS + 32'(tb_off));

    logic               r_s1_v, r_fwd;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic [COUNT_W-1:0] r_fwd_val;
    logic [COUNT_W-1:0] cnt_q, c_s1, inc;

    assign c_s1 = r_fwd ? r_fwd_val : cnt_q;
    assign inc  = (c_s1 == hec_pkg::COUNT_MAX) ? hec_pkg::COUNT_MAX : c_s1 + 1'b1;

    // ---------------- region sweep ----------------
    logic [hec_pkg::REG_W-1:0] r_reg;
    logic [ADDR_W-1:0]   base;
    logic [SK_W-1:0]     r_k, r_sj;
    logic                r_kdone, r_sv;
    logic [COUNT_W-1:0]  r_cprev, c_cur;
    logic signed [DIFF_W-1:0] dval, r_max;
    logic [SK_W-1:0]     r_peak;
    logic                sweep_rd;

    assign base     = ADDR_W'(32'(r_reg) * NUM_BINS);
    assign sweep_rd = (r_state == S_SWEEP) && !r_kdone && (r_k != SK_W'(NUM_BINS));
    assign c_cur    = (r_sj == SK_W'(NUM_BINS)) ? '0 : cnt_q;
    assign dval     = DIFF_W'({1'b0, r_cprev}) - DIFF_W'({1'b0, c_cur});

    // ---------------- window sum ----------------
    logic [WN_W-1:0]      r_wn;
    logic signed [KW-1:0] wk;
    logic                 wk_in, win_rd;
    logic                 r_p1_v, r_p2_v;
    logic [BIN_W-1:0]     r_p1_bin;
    logic [DIFF_W-1:0]    diff_q;
    logic [CEN_W-1:0]     center;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DIFF_W-1:0] r_p2_d;
    logic signed [ACC_W-1:0]  r_num;
    logic signed [DEN_W-1:0]  r_den;

    assign wk     = KW'(r_peak) - KW'(HALF_WINDOW) + KW'(r_wn);
    assign wk_in  = (wk >= KW'(1)) && (wk <= KW'(NUM_BINS));
    assign win_rd = (r_state == S_WIN) && (r_wn != WN_W'(2 * HALF_WINDOW));
    assign center = {CW'(r_wl) + CW'(r_p1_bin), 8'h80};

    // ---------------- count RAM ports ----------------
    logic               cnt_we;
    logic [ADDR_W-1:0]  cnt_waddr, cnt_raddr, r_clr;
    logic [COUNT_W-1:0] cnt_wdata;
    logic               diff_we;

    always_comb begin
        cnt_raddr = sweep_rd ? base + ADDR_W'(r_k) : hit_addr;
        if (r_state == S_CLEAR) begin
            cnt_we    = 1'b1;
            cnt_waddr = r_clr;
            cnt_wdata = '0;
        end else if (sweep_rd) begin
            // counts are cleared as they are read
            cnt_we    = 1'b1;
            cnt_waddr = base + ADDR_W'(r_k);
            cnt_wdata = '0;
        end else begin
            cnt_we    = r_s1_v;
            cnt_waddr = r_s1_addr;
            cnt_wdata = inc;
        end
    end

    assign diff_we = (r_state == S_SWEEP) && r_sv && (r_sj != '0);

    hec_ram #(.WIDTH(COUNT_W), .DEPTH(DEPTH)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_q)
    );

    hec_ram #(.WIDTH(DIFF_W), .DEPTH(NUM_BINS)) u_diff_ram (
        .i_clk   (i_clk),
        .i_we    (diff_we),
        .i_waddr (BIN_W'(r_sj - 1'b1)),
        .i_wdata (dval),
        .i_raddr (BIN_W'(wk - KW'(1))),
        .o_rdata (diff_q)
    );

    // ---------------- divider ----------------
    hec_pkg::t_div_req div_req;
    hec_pkg::t_div_rsp div_rsp;
    logic              r_dbusy;

    assign div_req.start = (r_state == S_DIV) && !r_dbusy && (r_den != '0);
    assign div_req.num   = hec_pkg::DIV_NUM_W'(r_num);
    assign div_req.den   = hec_pkg::DIV_DEN_W'(r_den);

    hec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ---------------- output register ----------------
    logic                             r_ov, r_zw;
    logic signed [hec_pkg::EDGE_W-1:0] r_edge;

    assign o_res.valid       = r_ov;
    assign o_res.region      = r_reg;
    assign o_res.edge_time   = r_edge;
    assign o_res.zero_weight = r_zw;
    assign o_res.last_region = (r_reg == hec_pkg::REG_W'(NUM_REGIONS - 1));

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl      <= hec_pkg::WINDOW_LOW_RST;
            r_row_lim <= hec_pkg::INNER_ROW_RST;
            r_sec_lim <= hec_pkg::SIDE_SEC_RST;
        end else if (i_cfg.valid) begin
            unique case (hec_pkg::t_cfg_idx'(i_cfg.index))
                hec_pkg::CFG_WINDOW_LOW:  r_wl      <= i_cfg.data;
                hec_pkg::CFG_INNER_ROW:   r_row_lim <= i_cfg.data[hec_pkg::ROW_W-1:0];
                hec_pkg::CFG_SIDE_SECTOR: r_sec_lim <= i_cfg.data[hec_pkg::SEC_W-1:0];
                default: ;
            endcase
        end
    end

    // payload and datapath registers
    always_ff @(posedge i_clk) begin
        if (hit_acc) begin
            r_s1_addr <= hit_addr;
            r_fwd     <= r_s1_v && (r_s1_addr == hit_addr);
            r_fwd_val <= inc;
        end
        if (r_state == S_SWEEP && r_sv) begin
            r_cprev <= c_cur;
            if (r_sj == SK_W'(1) || (r_sj != '0 && dval > r_max)) begin
                r_max  <= dval;
                r_peak <= r_sj;
            end
        end
        r_sj     <= r_k;
        r_p1_bin <= BIN_W'(wk - KW'(1));
        r_prod   <= PROD_W'($signed(diff_q) * $signed({1'b0, center}));
        r_p2_d   <= $signed(diff_q);
        if (r_state == S_SWEEP) begin
            r_num <= '0;
            r_den <= '0;
        end else if (r_p2_v) begin
            r_num <= r_num + ACC_W'(r_prod);
            r_den <= r_den + DEN_W'(r_p2_d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_s1_v  <= 1'b0;
            r_reg   <= '0;
            r_k     <= '0;
            r_kdone <= 1'b0;
            r_sv    <= 1'b0;
            r_wn    <= '0;
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_dbusy <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_s1_v <= hit_acc && in_win;
            r_p1_v <= win_rd && wk_in;
            r_p2_v <= r_p1_v;
            r_sv   <= sweep_rd || ((r_state == S_SWEEP) && !r_kdone);
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (hit_acc && i_hit.last_hit) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // last count write lands here
                    r_reg   <= '0;
                    r_k     <= '0;
                    r_kdone <= 1'b0;
                    r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (!r_kdone) begin
                        if (r_k == SK_W'(NUM_BINS)) begin
                            r_kdone <= 1'b1;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                    if (r_sv && r_sj == SK_W'(NUM_BINS)) begin
                        r_wn    <= '0;
                        r_state <= S_WIN;
                    end
                end
                S_WIN: begin
                    if (win_rd) begin
                        r_wn <= r_wn + 1'b1;
                    end else if (!r_p1_v && !r_p2_v) begin
                        r_dbusy <= 1'b0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_den == '0) begin
                        r_edge  <= '0;
                        r_zw    <= 1'b1;
                        r_ov    <= 1'b1;
                        r_state <= S_OUT;
                    end else if (!r_dbusy) begin
                        r_dbusy <= 1'b1;
                    end else if (div_rsp.done) begin
                        r_edge  <= div_rsp.quot;
                        r_zw    <= 1'b0;
                        r_ov    <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_res.ready) begin
                        r_ov <= 1'b0;
                        if (r_reg == hec_pkg::REG_W'(NUM_REGIONS - 1)) begin
                            r_state <= S_RUN;
                        end else begin
                            r_reg   <= r_reg + 1'b1;
                            r_k     <= '0;
                            r_kdone <= 1'b0;
                            r_state <= S_SWEEP;
                        end
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end
endmodule

[hw/rtl/hec_checker.sv]
module hec_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              hit_valid,
    input logic                              hit_ready,
    input logic                              hit_last,
    input logic                              res_valid,
    input logic                              res_ready,
    input logic [hec_pkg::REG_W-1:0]         res_region,
    input logic signed [hec_pkg::EDGE_W-1:0] res_edge,
    input logic                              res_zero,
    input logic                              res_lastr
);
    // no hit is taken while results of an event are pending
    a_no_hit_during_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !hit_ready)
        else $error("hit ready while result pending");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (res_lastr == (res_region == 2'd3)))
        else $error("last_region does not match region");

    a_zero_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res_zero) |-> (res_edge == '0))
        else $error("zero weight with nonzero edge");

    a_stop_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hit_valid && hit_ready && hit_last) |=> !hit_ready)
        else $error("hits accepted after last hit");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_edge) && $stable(res_region)))
        else $error("result changed while stalled");
endmodule

bind histogram_edge_centroid_top hec_checker u_hec_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .hit_valid  (i_hit.valid),
    .hit_ready  (i_hit.ready),
    .hit_last   (i_hit.last_hit),
    .res_valid  (o_res.valid),
    .res_ready  (o_res.ready),
    .res_region (o_res.region),
    .res_edge   (o_res.edge_time),
    .res_zero   (o_res.zero_weight),
    .res_lastr  (o_res.last_region)
);
